### design/dae_pkg.sv
// shared constants, command and status types for the duration alignment expander
`default_nettype none

package dae_pkg;

   // limits of the length regulator
   localparam int MAX_DURATION = 63;
   localparam int MAX_FRAMES   = 4096;
   localparam int MAX_TOKENS   = 512;

   // field widths
   localparam int SPEED_W   = 12;
   localparam int VTOK_W    = 10;
   localparam int DUR_W     = 19;
   localparam int TOK_IDX_W = 9;
   localparam int FRM_W     = 12;
   localparam int NFR_W     = 6;
   localparam int TOT_W     = 13;

   // internal widths
   localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
   localparam int QBITS  = $clog2(MAX_DURATION + 1);
   localparam int MAG_W  = DUR_W - 1;
   localparam int NUM_W  = MAG_W + 2;
   localparam int DEN_W  = SPEED_W + 1;
   localparam int STEP_W = $clog2(QBITS + 1);

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes (address bit 2)
   localparam logic [0:0] REG_SPEED        = 1'b0;
   localparam logic [0:0] REG_VALID_TOKENS = 1'b1;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;
   localparam logic [VTOK_W-1:0]  VTOK_RESET  = 10'd512;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic finish;
      logic emit;
   } dae_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic div_last;
      logic rsp_free;
      logic emit_last;
   } dae_stat_type;

endpackage

`default_nettype wire

### design/dae_csr.sv
// configuration registers behind the apb-style port
`default_nettype none

module dae_csr
   import dae_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire [CSR_ADDR_W-1:0]   paddr,
   input  wire [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output logic [SPEED_W-1:0]     speed,
   output logic [VTOK_W-1:0]      valid_tokens
);

   logic [SPEED_W-1:0] speed_ff;
   logic [SPEED_W-1:0] speed_in;
   logic [VTOK_W-1:0]  vtok_ff;
   logic [VTOK_W-1:0]  vtok_in;
   logic               wr_en;
   logic [0:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   // register write decode
   always_comb begin
      speed_in = speed_ff;
      vtok_in  = vtok_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SPEED:        speed_in = pwdata[SPEED_W-1:0];
            REG_VALID_TOKENS: vtok_in  = pwdata[VTOK_W-1:0];
            default:          speed_in = speed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
         vtok_ff  <= VTOK_RESET;
      end else begin
         speed_ff <= speed_in;
         vtok_ff  <= vtok_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_SPEED:        prdata = CSR_DATA_W'(speed_ff);
         REG_VALID_TOKENS: prdata = CSR_DATA_W'(vtok_ff);
         default:          prdata = '0;
      endcase
   end

   assign speed        = speed_ff;
   assign valid_tokens = vtok_ff;

endmodule

`default_nettype wire

### design/dae_ctrl.sv
// sequencing state machine: accept, divide, finish, emit frames
`default_nettype none

module dae_ctrl
   import dae_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire dae_stat_type stat,
   output dae_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.skip) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
               if (stat.div_last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/dae_dpath.sv
// datapath: bit-serial rounding divider, frame totals and result register
`default_nettype none

module dae_dpath
   import dae_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire [SPEED_W-1:0]      speed,
   input  wire [VTOK_W-1:0]       valid_tokens,
   input  wire signed [DUR_W-1:0] req_duration,
   input  wire                    req_last_token,
   input  wire                    rsp_ready,
   input  wire dae_cmd_type       cmd,
   output dae_stat_type           stat,
   output logic                   rsp_valid,
   output logic [TOK_IDX_W-1:0]   rsp_token_index,
   output logic [FRM_W-1:0]       rsp_frame_index,
   output logic [NFR_W-1:0]       rsp_token_frames,
   output logic [TOT_W-1:0]       rsp_token_start,
   output logic                   rsp_has_frame,
   output logic                   rsp_last,
   output logic [TOT_W-1:0]       rsp_sequence_total,
   output logic                   rsp_overflow
);

   // divider registers
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QBITS-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              big_ff, big_in;
   logic              skip_ff, skip_in;
   logic              real_ff, real_in;
   logic              ltok_ff, ltok_in;

   // per-token results
   logic [NFR_W-1:0]  nfr_ff, nfr_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [NFR_W-1:0]  emit_ff, emit_in;
   logic [NFR_W-1:0]  k_ff, k_in;

   // sequence state
   logic [TOT_W-1:0]  run_total_ff, run_total_in;
   logic [CNT_W-1:0]  tok_cnt_ff, tok_cnt_in;
   logic              ovf_seen_ff, ovf_seen_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [TOK_IDX_W-1:0] out_tok_ff, out_tok_in;
   logic [FRM_W-1:0]     out_frm_ff, out_frm_in;
   logic [NFR_W-1:0]     out_nfr_ff, out_nfr_in;
   logic [TOT_W-1:0]     out_start_ff, out_start_in;
   logic                 out_has_ff, out_has_in;
   logic                 out_last_ff, out_last_in;
   logic [TOT_W-1:0]     out_seq_ff, out_seq_in;
   logic                 out_ovf_ff, out_ovf_in;

   // helpers
   logic [SPEED_W-1:0] speed_eff;
   logic               tok_real;
   logic [NUM_W-1:0]   trial;
   logic               ge;
   logic [QBITS-1:0]   quo_min1;
   logic               dur_sat;
   logic [NFR_W-1:0]   nfr_fin;
   logic [TOT_W:0]     sum;
   logic               tot_sat;
   logic [TOT_W-1:0]   total_fin;
   logic               emit_last;
   logic [TOT_W-1:0]   frame_pos;

   assign speed_eff = (speed == '0) ? SPEED_W'(1) : speed;
   assign tok_real  = (32'(tok_cnt_ff) < 32'(valid_tokens)) &&
                      (32'(tok_cnt_ff) < MAX_TOKENS);

   // one restoring step per cycle, top step only detects saturation
   assign trial = NUM_W'(den_ff) << step_ff;
   assign ge    = (num_ff >= trial);

   // frame count of the token and the clipped total
   assign quo_min1  = (quo_ff == '0) ? QBITS'(1) : quo_ff;
   assign dur_sat   = !skip_ff && (big_ff || (32'(quo_ff) > MAX_DURATION));
   assign nfr_fin   = skip_ff ? (real_ff ? NFR_W'(1) : '0) :
                      dur_sat ? NFR_W'(MAX_DURATION) : NFR_W'(quo_min1);
   assign sum       = (TOT_W+1)'(run_total_ff) + (TOT_W+1)'(nfr_fin);
   assign tot_sat   = (sum > (TOT_W+1)'(MAX_FRAMES));
   assign total_fin = tot_sat ? TOT_W'(MAX_FRAMES) : sum[TOT_W-1:0];

   assign emit_last = (emit_ff == '0) || (NFR_W'(k_ff + NFR_W'(1)) == emit_ff);
   assign frame_pos = run_total_ff + TOT_W'(k_ff);

   // divider and token working registers
   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      big_in   = big_ff;
      skip_in  = skip_ff;
      real_in  = real_ff;
      ltok_in  = ltok_ff;
      nfr_in   = nfr_ff;
      total_in = total_ff;
      emit_in  = emit_ff;
      k_in     = k_ff;
      if (cmd.load) begin
         num_in  = NUM_W'({req_duration[MAG_W-1:0], 1'b0}) + NUM_W'(speed_eff);
         den_in  = {speed_eff, 1'b0};
         quo_in  = '0;
         step_in = STEP_W'(QBITS);
         big_in  = 1'b0;
         skip_in = req_duration[DUR_W-1] | ~tok_real;
         real_in = tok_real;
         ltok_in = req_last_token;
      end
      if (cmd.div_step) begin
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(QBITS)) begin
            big_in = ge;
         end else begin
            quo_in = {quo_ff[QBITS-2:0], ge};
            if (ge) begin
               num_in = num_ff - trial;
            end
         end
      end
      if (cmd.finish) begin
         nfr_in   = nfr_fin;
         total_in = total_fin;
         emit_in  = NFR_W'(total_fin - run_total_ff);
         k_in     = '0;
      end
      if (cmd.emit) begin
         k_in = k_ff + NFR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      big_ff   <= big_in;
      skip_ff  <= skip_in;
      real_ff  <= real_in;
      ltok_ff  <= ltok_in;
      nfr_ff   <= nfr_in;
      total_ff <= total_in;
      emit_ff  <= emit_in;
      k_ff     <= k_in;
   end

   // sequence state: sticky overflow at finish, commit on the last item of a token
   always_comb begin
      run_total_in = run_total_ff;
      tok_cnt_in   = tok_cnt_ff;
      ovf_seen_in  = ovf_seen_ff;
      if (cmd.finish) begin
         ovf_seen_in = ovf_seen_ff | dur_sat | tot_sat;
      end
      if (cmd.emit && emit_last) begin
         if (ltok_ff) begin
            run_total_in = '0;
            tok_cnt_in   = '0;
            ovf_seen_in  = 1'b0;
         end else begin
            run_total_in = total_ff;
            if (32'(tok_cnt_ff) < MAX_TOKENS) begin
               tok_cnt_in = tok_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_total_ff <= '0;
         tok_cnt_ff   <= '0;
         ovf_seen_ff  <= 1'b0;
      end else begin
         run_total_ff <= run_total_in;
         tok_cnt_ff   <= tok_cnt_in;
         ovf_seen_ff  <= ovf_seen_in;
      end
   end

   // result register, loaded when empty or being taken
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_tok_in   = out_tok_ff;
      out_frm_in   = out_frm_ff;
      out_nfr_in   = out_nfr_ff;
      out_start_in = out_start_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      out_seq_in   = out_seq_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_tok_in   = tok_cnt_ff[TOK_IDX_W-1:0];
         out_has_in   = (emit_ff != '0);
         out_frm_in   = (emit_ff != '0) ? frame_pos[FRM_W-1:0] : '0;
         out_nfr_in   = nfr_ff;
         out_start_in = run_total_ff;
         out_last_in  = emit_last;
         out_seq_in   = (emit_last && ltok_ff) ? total_ff : '0;
         out_ovf_in   = ovf_seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff   <= out_tok_in;
      out_frm_ff   <= out_frm_in;
      out_nfr_ff   <= out_nfr_in;
      out_start_ff <= out_start_in;
      out_has_ff   <= out_has_in;
      out_last_ff  <= out_last_in;
      out_seq_ff   <= out_seq_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // status back to the controller
   assign stat.skip      = skip_ff;
   assign stat.div_last  = (step_ff == '0);
   assign stat.rsp_free  = ~out_valid_ff | rsp_ready;
   assign stat.emit_last = emit_last;

   assign rsp_valid          = out_valid_ff;
   assign rsp_token_index    = out_tok_ff;
   assign rsp_frame_index    = out_frm_ff;
   assign rsp_token_frames   = out_nfr_ff;
   assign rsp_token_start    = out_start_ff;
   assign rsp_has_frame      = out_has_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_sequence_total = out_seq_ff;
   assign rsp_overflow       = out_ovf_ff;

endmodule

`default_nettype wire

### design/duration_alignment_expander.sv
// top level of the duration alignment expander (length regulator)
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    duration, last_token
//   rsp       out        rsp_valid/rsp_ready    one item per frame of the token, one if it has none
//   csr       in/out     psel/penable/pwrite    speed (addr 0), valid_tokens (addr 4)
//
// an item passes an accept step, the one-bit-per-cycle rounding divider and
// a finish step, then gives one result item per cycle while rsp_ready is high,
// max(1, frames) items in all, before the block is ready again.
// padding tokens and negative durations bypass the divider steps.
// synchronous reset clears the sequence state, the handshakes and the csr registers.
// a stalled rsp holds the result register and the emit sequencer.
`default_nettype none

module duration_alignment_expander
   import dae_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   // input items
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire signed [DUR_W-1:0] req_duration,
   input  wire                    req_last_token,
   // result items
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [TOK_IDX_W-1:0]   rsp_token_index,
   output logic [FRM_W-1:0]       rsp_frame_index,
   output logic [NFR_W-1:0]       rsp_token_frames,
   output logic [TOT_W-1:0]       rsp_token_start,
   output logic                   rsp_has_frame,
   output logic                   rsp_last,
   output logic [TOT_W-1:0]       rsp_sequence_total,
   output logic                   rsp_overflow,
   // configuration
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire [CSR_ADDR_W-1:0]   paddr,
   input  wire [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [SPEED_W-1:0] speed;
   logic [VTOK_W-1:0]  valid_tokens;
   dae_cmd_type        cmd;
   dae_stat_type       stat;

   // configuration registers
   dae_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .speed        (speed),
      .valid_tokens (valid_tokens)
   );

   // sequencer
   dae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // divider, totals and result register
   dae_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .speed              (speed),
      .valid_tokens       (valid_tokens),
      .req_duration       (req_duration),
      .req_last_token     (req_last_token),
      .rsp_ready          (rsp_ready),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_token_index    (rsp_token_index),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_token_frames   (rsp_token_frames),
      .rsp_token_start    (rsp_token_start),
      .rsp_has_frame      (rsp_has_frame),
      .rsp_last           (rsp_last),
      .rsp_sequence_total (rsp_sequence_total),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire

### design/dae_checker.sv
// port-level checks for the duration alignment expander and their bind
`default_nettype none

module dae_checker
   import dae_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire [TOK_IDX_W-1:0]  rsp_token_index,
   input wire [FRM_W-1:0]      rsp_frame_index,
   input wire [NFR_W-1:0]      rsp_token_frames,
   input wire [TOT_W-1:0]      rsp_token_start,
   input wire                  rsp_has_frame,
   input wire                  rsp_last,
   input wire [TOT_W-1:0]      rsp_sequence_total
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_index) &&
      $stable(rsp_token_index))
      else $error("stalled result item changed");

   // the block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // a token without frames gives a single closing item at frame zero
   a_empty_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_frame |-> rsp_last && (rsp_frame_index == '0))
      else $error("frameless item not the single last item");

   // the sequence total shows only on a closing item
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sequence_total != '0) |-> rsp_last)
      else $error("sequence total on a non-last item");

   // a frame lies within its token's span
   a_frame_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_frame |->
      (TOT_W'(rsp_frame_index) >= rsp_token_start) &&
      (TOT_W'(rsp_frame_index) < (rsp_token_start + TOT_W'(rsp_token_frames))))
      else $error("frame index outside token span");

endmodule

bind duration_alignment_expander dae_checker u_dae_checker (.*);

`default_nettype wire
